// ===== rtl/uartrx_pkg.sv =====
package uartrx_pkg;

  // receive fifo geometry
  localparam int RX_DEPTH = 16;
  localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CNT_W    = $clog2(RX_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;

  // register offsets
  localparam logic [11:0] OFF_LINE  = 12'h000;
  localparam logic [11:0] OFF_UCTL  = 12'h004;
  localparam logic [11:0] OFF_FCTL  = 12'h008;
  localparam logic [11:0] OFF_MCTL  = 12'h00c;
  localparam logic [11:0] OFF_STAT  = 12'h010;
  localparam logic [11:0] OFF_ERR   = 12'h014;
  localparam logic [11:0] OFF_FSTAT = 12'h018;
  localparam logic [11:0] OFF_MSTAT = 12'h01c;
  localparam logic [11:0] OFF_TX    = 12'h020;
  localparam logic [11:0] OFF_RX    = 12'h024;
  localparam logic [11:0] OFF_BAUD  = 12'h028;
  localparam logic [11:0] OFF_SLOT  = 12'h02c;

  localparam logic [31:0] UCON_RESET    = 32'h0000_3000;
  localparam logic [31:0] STAT_BASE     = 32'h0000_0006;
  localparam logic [31:0] FSTAT_FULL    = 32'h0000_0100;
  localparam logic [31:0] FSTAT_MASK    = 32'h0000_01ff;
  localparam logic [31:0] MSTAT_CTS     = 32'h0000_0001;
  localparam logic [31:0] FCON_KEEP     = 32'hffff_fff9;
  localparam logic [1:0]  RX_MODE_IRQ   = 2'b01;
  localparam int          UCON_LOOPBACK = 5;
  localparam int          FCON_CLEAR    = 1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] address;
    logic [31:0] write_data;
    logic [7:0]  line_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_dropped;
    logic        rx_space;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/uartrx_ctrl.sv =====
module uartrx_ctrl
  import uartrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.execute = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a captured item is worked on before the next one is taken
  a_capture_then_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> in_stall)
    else $error("input taken again right after a capture");

  // capture and execute are never issued together
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

  // a blocked result keeps the item in execution
  a_exec_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && !status.out_free) |=> (state == ST_EXEC && in_stall))
    else $error("item left execution while output was blocked");
`endif

endmodule

// ===== rtl/uartrx_dp.sv =====
module uartrx_dp
  import uartrx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [31:0] line_control;
  logic [31:0] uart_control;
  logic [31:0] fifo_control;
  logic [31:0] modem_control;
  logic [31:0] baud_divisor;
  logic [31:0] divisor_slot;

  logic [7:0]       rx_store [RX_DEPTH];
  logic [7:0]       rd_byte;
  logic [PTR_W-1:0] rx_head;
  logic [CNT_W-1:0] rx_count;

  in_item_t item;

  logic             is_read, is_write, is_line;
  logic             fifo_full, fifo_empty;
  logic             push_req, push_ok, pop, clear;
  logic [7:0]       push_byte;
  logic [SUM_W-1:0] wr_sum;
  logic [SUM_W-1:0] wr_slot;
  logic [PTR_W-1:0] rx_head_next;
  logic [CNT_W-1:0] rx_count_next;
  logic [31:0]      uart_control_next;
  logic [31:0]      read_value;
  out_item_t        result;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item    <= in_data;
      rd_byte <= rx_store[rx_head];
    end
  end

  assign is_read    = (item.kind == KIND_READ);
  assign is_write   = (item.kind == KIND_WRITE);
  assign is_line    = (item.kind == KIND_LINE);
  assign fifo_full  = (rx_count == CNT_W'(RX_DEPTH));
  assign fifo_empty = (rx_count == '0);

  assign push_req  = is_line ||
                     (is_write && item.address == OFF_TX && uart_control[UCON_LOOPBACK]);
  assign push_ok   = push_req && !fifo_full;
  assign push_byte = is_line ? item.line_byte : item.write_data[7:0];
  assign pop       = is_read && item.address == OFF_RX && !fifo_empty;
  assign clear     = is_write && item.address == OFF_FCTL && item.write_data[FCON_CLEAR];

  // tail slot, wrapped once
  assign wr_sum  = SUM_W'(rx_head) + SUM_W'(rx_count);
  assign wr_slot = (wr_sum >= SUM_W'(RX_DEPTH)) ? wr_sum - SUM_W'(RX_DEPTH) : wr_sum;

  always_comb begin
    rx_head_next  = rx_head;
    rx_count_next = rx_count;
    priority if (clear) begin
      rx_head_next  = '0;
      rx_count_next = '0;
    end else if (push_ok) begin
      rx_count_next = rx_count + CNT_W'(1);
    end else if (pop) begin
      rx_count_next = rx_count - CNT_W'(1);
      rx_head_next  = (rx_head == PTR_W'(RX_DEPTH - 1)) ? '0 : rx_head + PTR_W'(1);
    end
  end

  assign uart_control_next = (is_write && item.address == OFF_UCTL) ? item.write_data
                                                                     : uart_control;

  always_comb begin
    unique case (item.address)
      OFF_LINE:  read_value = line_control;
      OFF_UCTL:  read_value = uart_control;
      OFF_FCTL:  read_value = fifo_control;
      OFF_MCTL:  read_value = modem_control;
      OFF_STAT:  read_value = STAT_BASE | {31'd0, !fifo_empty};
      OFF_FSTAT: read_value = (fifo_full ? FSTAT_FULL : 32'(rx_count)) & FSTAT_MASK;
      OFF_MSTAT: read_value = MSTAT_CTS;
      OFF_RX:    read_value = fifo_empty ? 32'd0 : {24'd0, rd_byte};
      OFF_BAUD:  read_value = baud_divisor;
      OFF_SLOT:  read_value = divisor_slot;
      default:   read_value = 32'd0;
    endcase
  end

  always_comb begin
    result.read_data  = is_read ? read_value : 32'd0;
    result.irq        = (rx_count_next != '0) && (uart_control_next[1:0] == RX_MODE_IRQ);
    result.tx_valid   = is_write && item.address == OFF_TX && !uart_control[UCON_LOOPBACK];
    result.tx_byte    = result.tx_valid ? item.write_data[7:0] : 8'd0;
    result.rx_dropped = push_req && fifo_full;
    result.rx_space   = (rx_count_next < CNT_W'(RX_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && push_ok) begin
      rx_store[wr_slot[PTR_W-1:0]] <= push_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_control  <= '0;
      uart_control  <= UCON_RESET;
      fifo_control  <= '0;
      modem_control <= '0;
      baud_divisor  <= '0;
      divisor_slot  <= '0;
      rx_head       <= '0;
      rx_count      <= '0;
    end else if (cmd.execute) begin
      rx_head      <= rx_head_next;
      rx_count     <= rx_count_next;
      uart_control <= uart_control_next;
      if (is_write) begin
        unique case (item.address)
          OFF_LINE: line_control  <= item.write_data;
          OFF_FCTL: fifo_control  <= item.write_data & FCON_KEEP;
          OFF_MCTL: modem_control <= item.write_data;
          OFF_BAUD: baud_divisor  <= item.write_data;
          OFF_SLOT: divisor_slot  <= item.write_data;
          default: ;
        endcase
      end
    end
  end

  // result register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/uart_rx_fifo_register_block.sv =====
// uart register file with a receive fifo
//
// in channel: in_valid / in_stall / in_data. one transaction is a bus read,
// a bus write or a byte received from the line; in_data.kind selects which.
// out channel: out_valid / out_stall / out_data. every input transaction
// yields exactly one result transaction carrying read data, the irq level,
// the transmit byte, the drop flag and the fifo space flag.
//
// a transaction taken from the in channel is captured into the item register,
// and the fifo head is read from the registered store read port at the same
// time; once the result register is free it is decoded, applied to the registers
// and loaded into the result register. a new one is taken only after that.
//
// reset (rst, synchronous): control registers go to their reset values
// (uart_control 0x3000, the rest zero) and the fifo becomes empty.
// when the receiver stalls, the result register holds its transaction and
// one more input transaction is still taken; it then waits in execution
// until the result register frees up.
module uart_rx_fifo_register_block
  import uartrx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: capture, then execute once the result register is free
  uartrx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // register file, receive fifo and result register
  uartrx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import uartrx_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  uart_rx_fifo_register_block i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the register file and receive fifo
  logic [31:0]      shadow_line = '0;
  logic [31:0]      shadow_ucon = UCON_RESET;
  logic [31:0]      shadow_fcon = '0;
  logic [31:0]      shadow_mcon = '0;
  logic [31:0]      shadow_baud = '0;
  logic [31:0]      shadow_slot = '0;
  logic [7:0]       rx_shadow [RX_DEPTH];
  logic [PTR_W-1:0] rx_head = '0;
  logic [CNT_W-1:0] rx_fill = '0;

  out_item_t expected_responses [$];
  int        response_errors  = 0;
  int        items_sent       = 0;
  bit        sender_gaps      = 1'b1;
  bit        receiver_stalls  = 1'b1;
  int        long_hold_cycles = 0;

  function automatic bit rx_push(input logic [7:0] b);
    if (rx_fill >= RX_DEPTH) return 1'b0;
    rx_shadow[PTR_W'((rx_head + rx_fill) % RX_DEPTH)] = b;
    rx_fill = rx_fill + 1'b1;
    return 1'b1;
  endfunction

  // register read, a read of the receive register pops
  function automatic logic [31:0] shadow_read(input logic [11:0] addr);
    logic [31:0] value;
    value = '0;
    case (addr)
      OFF_LINE:  value = shadow_line;
      OFF_UCTL:  value = shadow_ucon;
      OFF_FCTL:  value = shadow_fcon;
      OFF_MCTL:  value = shadow_mcon;
      OFF_STAT:  value = STAT_BASE | (rx_fill != 0);
      OFF_FSTAT: begin
        value = 32'(rx_fill);
        if (rx_fill == RX_DEPTH) value = FSTAT_FULL;
        value = value & FSTAT_MASK;
      end
      OFF_MSTAT: value = MSTAT_CTS;
      OFF_RX: begin
        if (rx_fill != 0) begin
          value   = 32'(rx_shadow[rx_head]);
          rx_head = PTR_W'((rx_head + 1) % RX_DEPTH);
          rx_fill = rx_fill - 1'b1;
        end
      end
      OFF_BAUD:  value = shadow_baud;
      OFF_SLOT:  value = shadow_slot;
      default:   value = '0;
    endcase
    return value;
  endfunction

  function automatic out_item_t predict_response(input in_item_t item);
    out_item_t resp;
    resp = '0;
    case (item.kind)
      KIND_READ: resp.read_data = shadow_read(item.address);
      KIND_WRITE: begin
        case (item.address)
          OFF_LINE: shadow_line = item.write_data;
          OFF_UCTL: shadow_ucon = item.write_data;
          OFF_FCTL: begin
            if (item.write_data[FCON_CLEAR]) begin
              rx_head = '0;
              rx_fill = '0;
            end
            shadow_fcon = item.write_data & FCON_KEEP;
          end
          OFF_MCTL: shadow_mcon = item.write_data;
          OFF_TX: begin
            if (shadow_ucon[UCON_LOOPBACK]) begin
              resp.rx_dropped = !rx_push(item.write_data[7:0]);
            end else begin
              resp.tx_valid = 1'b1;
              resp.tx_byte  = item.write_data[7:0];
            end
          end
          OFF_BAUD: shadow_baud = item.write_data;
          OFF_SLOT: shadow_slot = item.write_data;
          default: ;
        endcase
      end
      KIND_LINE: resp.rx_dropped = !rx_push(item.line_byte);
      default: ;
    endcase
    resp.irq      = (rx_fill != 0) && (shadow_ucon[1:0] == RX_MODE_IRQ);
    resp.rx_space = rx_fill < RX_DEPTH;
    return resp;
  endfunction

  function automatic logic [11:0] random_reg_offset();
    case ($urandom_range(0, 11))
      0:       return OFF_LINE;
      1:       return OFF_UCTL;
      2:       return OFF_FCTL;
      3:       return OFF_MCTL;
      4:       return OFF_STAT;
      5:       return OFF_ERR;
      6:       return OFF_FSTAT;
      7:       return OFF_MSTAT;
      8:       return OFF_TX;
      9:       return OFF_RX;
      10:      return OFF_BAUD;
      default: return OFF_SLOT;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    item.kind       = kind_t'($urandom_range(0, 3));
    item.address    = $urandom_range(0, 1) ? random_reg_offset()
                                           : 12'($urandom_range(0, 4095));
    item.write_data = $urandom();
    item.line_byte  = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // valid stays high after acceptance, the next call lowers it only for a gap
  task automatic send_item(input in_item_t item);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_responses.push_back(predict_response(item));
    items_sent++;
  endtask

  task automatic bus_read(input logic [11:0] addr);
    in_item_t item;
    item         = random_item();
    item.kind    = KIND_READ;
    item.address = addr;
    send_item(item);
  endtask

  task automatic bus_write(input logic [11:0] addr, input logic [31:0] data);
    in_item_t item;
    item            = random_item();
    item.kind       = KIND_WRITE;
    item.address    = addr;
    item.write_data = data;
    send_item(item);
  endtask

  task automatic line_rx(input logic [7:0] b);
    in_item_t item;
    item           = random_item();
    item.kind      = KIND_LINE;
    item.line_byte = b;
    send_item(item);
  endtask

  // sender pause: nothing offered until every response is back
  task automatic wait_all_responses();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_register_map();
    bus_read(OFF_LINE);
    bus_read(OFF_UCTL);
    bus_read(OFF_FCTL);
    bus_read(OFF_MCTL);
    bus_read(OFF_STAT);
    bus_read(OFF_ERR);
    bus_read(OFF_FSTAT);
    bus_read(OFF_MSTAT);
    bus_read(OFF_TX);
    bus_read(OFF_RX);
    bus_read(OFF_BAUD);
    bus_read(OFF_SLOT);
  endtask

  task automatic test_special_cases();
    in_item_t item;
    bus_write(OFF_LINE, 32'hffff_ffff);
    bus_write(OFF_FCTL, 32'hffff_ffff);
    bus_write(OFF_STAT, 32'hffff_ffff);      // status write ignored
    bus_write(OFF_LINE + 12'd1, 32'h0);      // unaligned write ignored
    bus_read(OFF_LINE);
    bus_read(OFF_FCTL);
    bus_read(12'hfff);                       // unmapped read
    bus_write(OFF_TX, 32'hffff_ffa5);        // goes out on the line
    bus_write(OFF_UCTL, 32'h0000_0021);      // loopback, rx mode irq
    bus_write(OFF_TX, 32'h0000_00ff);        // looped into the fifo
    line_rx(8'h00);
    line_rx(8'hff);
    item      = random_item();
    item.kind = KIND_IDLE;
    send_item(item);
    bus_read(OFF_FSTAT);
    bus_write(OFF_RX, 32'h0);                // receive write ignored
    repeat (4) bus_read(OFF_RX);             // last pop hits an empty fifo
    bus_write(OFF_UCTL, UCON_RESET);
  endtask

  task automatic test_fifo_overflow();
    bus_write(OFF_UCTL, 32'h0000_0001);
    repeat (RX_DEPTH + 2) line_rx(8'($urandom_range(0, 255)));
    bus_write(OFF_UCTL, 32'h0000_0021);
    bus_write(OFF_TX, $urandom());           // loopback into a full fifo
    bus_read(OFF_FSTAT);
    bus_read(OFF_STAT);
    repeat (4) bus_read(OFF_RX);
    bus_write(OFF_FCTL, 32'h0000_0002);      // clear with bytes still queued
    bus_read(OFF_FSTAT);
    bus_read(OFF_RX);
    bus_write(OFF_UCTL, UCON_RESET);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    sender_gaps      = 1'b0;
    long_hold_cycles = 60;
    repeat (20) begin
      line_rx(8'($urandom_range(0, 255)));
      bus_read($urandom_range(0, 1) ? OFF_RX : random_reg_offset());
    end
    wait_all_responses();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    int          stop_at;
    int          n;
    logic [11:0] addr;
    logic [31:0] data;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill burst, transmit writes loop back when loopback is on
          n = $urandom_range(1, RX_DEPTH + 2);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) bus_write(OFF_TX, $urandom());
            else line_rx(8'($urandom_range(0, 255)));
          end
        end
        3, 4: begin
          n = $urandom_range(1, RX_DEPTH + 2);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) bus_read(OFF_FSTAT);
            else bus_read(OFF_RX);
          end
        end
        5, 6: begin
          addr = random_reg_offset();
          bus_write(addr, $urandom());
          bus_read(addr);
        end
        7: begin
          data = $urandom();
          if ($urandom_range(0, 1)) data[1:0] = RX_MODE_IRQ;
          bus_write(OFF_UCTL, data);
        end
        default: repeat ($urandom_range(1, 8)) send_item(random_item());
      endcase
    end
  endtask

  // one draw of stall cycles per response, or a long hold when requested
  initial begin : result_receiver
    int hold;
    forever begin
      if (long_hold_cycles > 0) begin
        hold             = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        hold = receiver_stalls ? $urandom_range(0, 4) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  always @(posedge clk) begin : response_checker
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        if (response_errors < 10)
          $display("%0t: unexpected response rd=%h irq=%b tx=%b/%h drop=%b space=%b",
                   $realtime, out_data.read_data, out_data.irq, out_data.tx_valid,
                   out_data.tx_byte, out_data.rx_dropped, out_data.rx_space);
        response_errors++;
      end else begin
        want = expected_responses.pop_front();
        if (out_data.read_data !== want.read_data || out_data.irq !== want.irq ||
            out_data.tx_valid !== want.tx_valid || out_data.tx_byte !== want.tx_byte ||
            out_data.rx_dropped !== want.rx_dropped ||
            out_data.rx_space !== want.rx_space) begin
          if (response_errors < 10) begin
            $display("%0t: mismatch expected rd=%h irq=%b tx=%b/%h drop=%b space=%b",
                     $realtime, want.read_data, want.irq, want.tx_valid, want.tx_byte,
                     want.rx_dropped, want.rx_space);
            $display("%0t: mismatch got      rd=%h irq=%b tx=%b/%h drop=%b space=%b",
                     $realtime, out_data.read_data, out_data.irq, out_data.tx_valid,
                     out_data.tx_byte, out_data.rx_dropped, out_data.rx_space);
          end
          response_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_register_map();
    test_special_cases();
    wait_all_responses();
    test_fifo_overflow();
    wait_all_responses();
    test_backpressure();

    // idling on both sides, then none, then one side at a time
    test_random_traffic(275);
    wait_all_responses();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    test_random_traffic(275);
    wait_all_responses();
    sender_gaps = 1'b1;
    test_random_traffic(275);
    wait_all_responses();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b1;
    test_random_traffic(275);
    wait_all_responses();
    repeat (10) @(posedge clk);

    if (expected_responses.size() != 0) begin
      $display("responses never returned: %0d", expected_responses.size());
      response_errors++;
    end
    if (response_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
